@@ rtl/core/rmf_pkg.sv @@
package rmf_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [15:0] BROADCAST_ID = 16'hffff;

    typedef enum logic [2:0] {
        ST_DISABLED = 3'd0,
        ST_SLEEP    = 3'd1,
        ST_IDLE     = 3'd2,
        ST_LISTEN   = 3'd3,
        ST_RECEIVE  = 3'd4,
        ST_TRANSMIT = 3'd5,
        ST_ACKWAIT  = 3'd6
    } radio_state_t;

    localparam logic [3:0] ACT_ENABLE        = 4'd0;
    localparam logic [3:0] ACT_DISABLE       = 4'd1;
    localparam logic [3:0] ACT_SLEEP         = 4'd2;
    localparam logic [3:0] ACT_IDLE          = 4'd3;
    localparam logic [3:0] ACT_RECEIVE       = 4'd4;
    localparam logic [3:0] ACT_TRANSMIT      = 4'd5;
    localparam logic [3:0] ACT_SEND_COMPLETE = 4'd6;
    localparam logic [3:0] ACT_FRAME         = 4'd7;
    localparam logic [3:0] ACT_TX_DONE_QUERY = 4'd8;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BUSY    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;
    localparam logic [1:0] STAT_REJECT  = 2'd3;

    localparam logic [1:0] EV_REPLY   = 2'd0;
    localparam logic [1:0] EV_TXDONE  = 2'd1;
    localparam logic [1:0] EV_RXDONE  = 2'd2;
    localparam logic [1:0] EV_IGNORED = 2'd3;

    localparam logic [2:0] FTYPE_ACK = 3'd2;
    localparam logic [2:0] FTYPE_CMD = 3'd3;
    localparam int unsigned ACK_REQ_BIT = 5;

    localparam logic [1:0] DMODE_NONE     = 2'd0;
    localparam logic [1:0] DMODE_RESERVED = 2'd1;
    localparam logic [1:0] DMODE_SHORT    = 2'd2;
    localparam logic [1:0] DMODE_EXT      = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_PAN_ID      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_ADDR  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXT_ADDR    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PROMISCUOUS = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [4:0]  channel;
        logic [7:0]  frame_control_low;
        logic [7:0]  frame_control_high;
        logic [7:0]  seq_number;
        logic [15:0] dst_pan;
        logic [63:0] dst_addr;
    } in_word_t;

    typedef struct packed {
        radio_state_t mode;
        logic [4:0]   listen_channel;
        logic [7:0]   sent_seq;
        logic         sent_wants_ack;
        logic         sent_was_command;
        logic         pending_flag;
    } ctx_t;

    typedef struct packed {
        logic [15:0] pan_id;
        logic [15:0] short_addr;
        logic [63:0] ext_addr;
        logic        promiscuous;
    } cfg_t;

    typedef struct packed {
        logic [1:0]   status;
        logic [1:0]   event_kind;
        logic         data_pending;
        logic         send_ack;
        logic [7:0]   ack_seq;
        logic [4:0]   ack_channel;
        radio_state_t radio_state;
    } res_t;

endpackage

@@ rtl/core/rmf_step.sv @@
module rmf_step
(
    input  rmf_pkg::in_word_t word,
    input  rmf_pkg::ctx_t     ctx,
    input  rmf_pkg::cfg_t     cfg,
    output rmf_pkg::ctx_t     ctx_next,
    output rmf_pkg::res_t     res
);

    logic       pan_ok;
    logic       short_ok;
    logic       ext_ok;
    logic       frame_passes;
    logic [1:0] dmode;
    logic [2:0] ftype;
    logic       ack_req;

    // destination filter
    always_comb
    begin
        dmode    = word.frame_control_high[3:2];
        ftype    = word.frame_control_low[2:0];
        ack_req  = word.frame_control_low[rmf_pkg::ACK_REQ_BIT];
        pan_ok   = (word.dst_pan == rmf_pkg::BROADCAST_ID) || (word.dst_pan == cfg.pan_id);
        short_ok = (word.dst_addr[15:0] == rmf_pkg::BROADCAST_ID)
                   || (word.dst_addr[15:0] == cfg.short_addr);
        ext_ok   = (word.dst_addr == cfg.ext_addr);
        case (dmode)
            rmf_pkg::DMODE_NONE:     frame_passes = 1'b1;
            rmf_pkg::DMODE_SHORT:    frame_passes = pan_ok && short_ok;
            rmf_pkg::DMODE_EXT:      frame_passes = pan_ok && ext_ok;
            rmf_pkg::DMODE_RESERVED: frame_passes = 1'b0;
            default:                 frame_passes = 1'b0;
        endcase
    end

    // next state and result
    always_comb
    begin
        ctx_next         = ctx;
        res              = '0;
        res.status       = rmf_pkg::STAT_OK;
        res.event_kind   = rmf_pkg::EV_REPLY;
        unique case (word.action)
            rmf_pkg::ACT_ENABLE:
            begin
                if (ctx.mode == rmf_pkg::ST_DISABLED)
                    ctx_next.mode = rmf_pkg::ST_SLEEP;
                else
                    res.status = rmf_pkg::STAT_BUSY;
            end
            rmf_pkg::ACT_DISABLE:
            begin
                ctx_next.mode = rmf_pkg::ST_DISABLED;
            end
            rmf_pkg::ACT_SLEEP:
            begin
                if (ctx.mode == rmf_pkg::ST_IDLE)
                    ctx_next.mode = rmf_pkg::ST_SLEEP;
                else
                    res.status = rmf_pkg::STAT_BUSY;
            end
            rmf_pkg::ACT_IDLE:
            begin
                if (ctx.mode == rmf_pkg::ST_DISABLED || ctx.mode == rmf_pkg::ST_RECEIVE)
                    res.status = rmf_pkg::STAT_BUSY;
                else
                    ctx_next.mode = rmf_pkg::ST_IDLE;
            end
            rmf_pkg::ACT_RECEIVE:
            begin
                if (ctx.mode == rmf_pkg::ST_IDLE)
                begin
                    ctx_next.mode           = rmf_pkg::ST_LISTEN;
                    ctx_next.listen_channel = word.channel;
                end
                else
                begin
                    res.status = rmf_pkg::STAT_BUSY;
                end
            end
            rmf_pkg::ACT_TRANSMIT:
            begin
                if (ctx.mode == rmf_pkg::ST_IDLE)
                begin
                    ctx_next.mode             = rmf_pkg::ST_TRANSMIT;
                    ctx_next.pending_flag     = 1'b0;
                    ctx_next.sent_seq         = word.seq_number;
                    ctx_next.sent_wants_ack   = ack_req;
                    ctx_next.sent_was_command = (ftype == rmf_pkg::FTYPE_CMD);
                end
                else
                begin
                    res.status = rmf_pkg::STAT_BUSY;
                end
            end
            rmf_pkg::ACT_SEND_COMPLETE:
            begin
                if (ctx.mode != rmf_pkg::ST_TRANSMIT)
                begin
                    res.status     = rmf_pkg::STAT_INVALID;
                    res.event_kind = rmf_pkg::EV_IGNORED;
                end
                else if (ctx.sent_wants_ack)
                begin
                    ctx_next.mode = rmf_pkg::ST_ACKWAIT;
                end
                else
                begin
                    ctx_next.mode  = rmf_pkg::ST_IDLE;
                    res.event_kind = rmf_pkg::EV_TXDONE;
                end
            end
            rmf_pkg::ACT_FRAME:
            begin
                res.event_kind = rmf_pkg::EV_IGNORED;
                if (ctx.mode == rmf_pkg::ST_ACKWAIT)
                begin
                    if (ftype == rmf_pkg::FTYPE_ACK && word.seq_number == ctx.sent_seq)
                    begin
                        ctx_next.pending_flag = ctx.pending_flag | ctx.sent_was_command;
                        ctx_next.mode         = rmf_pkg::ST_IDLE;
                        res.event_kind        = rmf_pkg::EV_TXDONE;
                        res.data_pending      = ctx.pending_flag | ctx.sent_was_command;
                    end
                end
                else if (ctx.mode == rmf_pkg::ST_LISTEN && word.channel == ctx.listen_channel)
                begin
                    ctx_next.mode  = rmf_pkg::ST_IDLE;
                    res.event_kind = rmf_pkg::EV_RXDONE;
                    if (!cfg.promiscuous)
                    begin
                        if (!frame_passes)
                        begin
                            res.status = rmf_pkg::STAT_REJECT;
                        end
                        else if (ack_req)
                        begin
                            res.send_ack    = 1'b1;
                            res.ack_seq     = word.seq_number;
                            res.ack_channel = ctx.listen_channel;
                        end
                    end
                end
            end
            rmf_pkg::ACT_TX_DONE_QUERY:
            begin
                if (ctx.mode == rmf_pkg::ST_TRANSMIT || ctx.mode == rmf_pkg::ST_ACKWAIT)
                begin
                    ctx_next.mode    = rmf_pkg::ST_IDLE;
                    res.event_kind   = rmf_pkg::EV_TXDONE;
                    res.data_pending = ctx.pending_flag;
                end
                else
                begin
                    res.status = rmf_pkg::STAT_INVALID;
                end
            end
            default:
            begin
                res.event_kind = rmf_pkg::EV_IGNORED;
            end
        endcase
        res.radio_state = ctx_next.mode;
    end

endmodule

@@ rtl/core/radio_mac_state_and_rx_filter_top.sv @@
// a word passes from the input register through the combinational step into the result register
// throughput: one word per cycle while the receiver takes results, input register and result register both stall-aware
// the radio state advances when a word moves from the input register to the result register
// reset (asynchronous, active low): radio disabled, state and configuration registers and addresses zero,
// both pipeline registers empty
module radio_mac_state_and_rx_filter_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [rmf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [3:0]                        action,
    input  logic [4:0]                        channel,
    input  logic [7:0]                        frame_control_low,
    input  logic [7:0]                        frame_control_high,
    input  logic [7:0]                        seq_number,
    input  logic [15:0]                       dst_pan,
    input  logic [63:0]                       dst_addr,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [1:0]                        event_kind,
    output logic                              data_pending,
    output logic                              send_ack,
    output logic [7:0]                        ack_seq,
    output logic [4:0]                        ack_channel,
    output logic [2:0]                        radio_state
);

    logic              in_valid_reg;
    rmf_pkg::in_word_t in_word_reg;
    logic              out_valid_reg;
    rmf_pkg::res_t     res_reg;
    rmf_pkg::res_t     res_next;
    rmf_pkg::ctx_t     ctx_reg;
    rmf_pkg::ctx_t     ctx_next;
    rmf_pkg::cfg_t     cfg_reg;
    logic              advance;
    logic              in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    rmf_step u_step
    (
        .word     (in_word_reg),
        .ctx      (ctx_reg),
        .cfg      (cfg_reg),
        .ctx_next (ctx_next),
        .res      (res_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rmf_pkg::REG_PAN_ID:      cfg_reg.pan_id      <= cfg_data[15:0];
                rmf_pkg::REG_SHORT_ADDR:  cfg_reg.short_addr  <= cfg_data[15:0];
                rmf_pkg::REG_EXT_ADDR:    cfg_reg.ext_addr    <= cfg_data;
                rmf_pkg::REG_PROMISCUOUS: cfg_reg.promiscuous <= cfg_data[0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // radio state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.mode             <= rmf_pkg::ST_DISABLED;
            ctx_reg.listen_channel   <= '0;
            ctx_reg.sent_seq         <= '0;
            ctx_reg.sent_wants_ack   <= 1'b0;
            ctx_reg.sent_was_command <= 1'b0;
            ctx_reg.pending_flag     <= 1'b0;
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload words
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg.action             <= action;
            in_word_reg.channel            <= channel;
            in_word_reg.frame_control_low  <= frame_control_low;
            in_word_reg.frame_control_high <= frame_control_high;
            in_word_reg.seq_number         <= seq_number;
            in_word_reg.dst_pan            <= dst_pan;
            in_word_reg.dst_addr           <= dst_addr;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign event_kind   = res_reg.event_kind;
    assign data_pending = res_reg.data_pending;
    assign send_ack     = res_reg.send_ack;
    assign ack_seq      = res_reg.ack_seq;
    assign ack_channel  = res_reg.ack_channel;
    assign radio_state  = res_reg.radio_state;

endmodule

@@ verif/tb_radio_mac_state_and_rx_filter_top.sv @@
module tb_radio_mac_state_and_rx_filter_top;

    import rmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int WORDS_PER_PHASE = 200;
    localparam int PHASES = 8;
    localparam int MAX_REPORTS = 40;
    localparam logic [3:0] ACT_UNKNOWN_TOP = 4'd15;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] action = ACT_IDLE;
    logic [4:0] channel = '0;
    logic [7:0] frame_control_low = '0;
    logic [7:0] frame_control_high = '0;
    logic [7:0] seq_number = '0;
    logic [15:0] dst_pan = '0;
    logic [63:0] dst_addr = '0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [1:0] event_kind;
    logic data_pending;
    logic send_ack;
    logic [7:0] ack_seq;
    logic [4:0] ack_channel;
    logic [2:0] radio_state;

    ctx_t radio_ctx = '0;
    cfg_t radio_cfg = '0;
    res_t reply_q[$];
    res_t want_reply;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_request = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int settings_count = 0;

    radio_mac_state_and_rx_filter_top u_top
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .action             (action),
        .channel            (channel),
        .frame_control_low  (frame_control_low),
        .frame_control_high (frame_control_high),
        .seq_number         (seq_number),
        .dst_pan            (dst_pan),
        .dst_addr           (dst_addr),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .event_kind         (event_kind),
        .data_pending       (data_pending),
        .send_ack           (send_ack),
        .ack_seq            (ack_seq),
        .ack_channel        (ack_channel),
        .radio_state        (radio_state)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic res_t radio_step(input in_word_t w);
        res_t r;
        logic pan_hit;
        logic addr_hit;
        r = '0;
        r.status = STAT_OK;
        r.event_kind = EV_REPLY;
        pan_hit = (w.dst_pan == BROADCAST_ID) || (w.dst_pan == radio_cfg.pan_id);
        case (w.frame_control_high[3:2])
            DMODE_NONE: addr_hit = 1'b1;
            DMODE_SHORT: addr_hit = pan_hit && (w.dst_addr[15:0] == BROADCAST_ID ||
                                               w.dst_addr[15:0] == radio_cfg.short_addr);
            DMODE_EXT: addr_hit = pan_hit && (w.dst_addr == radio_cfg.ext_addr);
            default: addr_hit = 1'b0;
        endcase
        case (w.action)
            ACT_ENABLE:
                if (radio_ctx.mode == ST_DISABLED)
                    radio_ctx.mode = ST_SLEEP;
                else
                    r.status = STAT_BUSY;
            ACT_DISABLE:
                radio_ctx.mode = ST_DISABLED;
            ACT_SLEEP:
                if (radio_ctx.mode == ST_IDLE)
                    radio_ctx.mode = ST_SLEEP;
                else
                    r.status = STAT_BUSY;
            ACT_IDLE:
                if (radio_ctx.mode == ST_DISABLED || radio_ctx.mode == ST_RECEIVE)
                    r.status = STAT_BUSY;
                else
                    radio_ctx.mode = ST_IDLE;
            ACT_RECEIVE:
                if (radio_ctx.mode == ST_IDLE)
                begin
                    radio_ctx.mode = ST_LISTEN;
                    radio_ctx.listen_channel = w.channel;
                end
                else
                    r.status = STAT_BUSY;
            ACT_TRANSMIT:
                if (radio_ctx.mode == ST_IDLE)
                begin
                    radio_ctx.mode = ST_TRANSMIT;
                    radio_ctx.pending_flag = 1'b0;
                    radio_ctx.sent_seq = w.seq_number;
                    radio_ctx.sent_wants_ack = w.frame_control_low[ACK_REQ_BIT];
                    radio_ctx.sent_was_command = (w.frame_control_low[2:0] == FTYPE_CMD);
                end
                else
                    r.status = STAT_BUSY;
            ACT_SEND_COMPLETE:
                if (radio_ctx.mode != ST_TRANSMIT)
                begin
                    r.status = STAT_INVALID;
                    r.event_kind = EV_IGNORED;
                end
                else if (radio_ctx.sent_wants_ack)
                    radio_ctx.mode = ST_ACKWAIT;
                else
                begin
                    radio_ctx.mode = ST_IDLE;
                    r.event_kind = EV_TXDONE;
                end
            ACT_FRAME:
            begin
                r.event_kind = EV_IGNORED;
                if (radio_ctx.mode == ST_ACKWAIT)
                begin
                    if (w.frame_control_low[2:0] == FTYPE_ACK &&
                        w.seq_number == radio_ctx.sent_seq)
                    begin
                        if (radio_ctx.sent_was_command)
                            radio_ctx.pending_flag = 1'b1;
                        radio_ctx.mode = ST_IDLE;
                        r.event_kind = EV_TXDONE;
                        r.data_pending = radio_ctx.pending_flag;
                    end
                end
                else if (radio_ctx.mode == ST_LISTEN && w.channel == radio_ctx.listen_channel)
                begin
                    r.event_kind = EV_RXDONE;
                    radio_ctx.mode = ST_IDLE;
                    if (!radio_cfg.promiscuous)
                    begin
                        if (!addr_hit)
                            r.status = STAT_REJECT;
                        else if (w.frame_control_low[ACK_REQ_BIT])
                        begin
                            r.send_ack = 1'b1;
                            r.ack_seq = w.seq_number;
                            r.ack_channel = radio_ctx.listen_channel;
                        end
                    end
                end
            end
            ACT_TX_DONE_QUERY:
                if (radio_ctx.mode == ST_TRANSMIT || radio_ctx.mode == ST_ACKWAIT)
                begin
                    radio_ctx.mode = ST_IDLE;
                    r.event_kind = EV_TXDONE;
                    r.data_pending = radio_ctx.pending_flag;
                end
                else
                    r.status = STAT_INVALID;
            default:
                r.event_kind = EV_IGNORED;
        endcase
        r.radio_state = radio_ctx.mode;
        return r;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.action = ACT_IDLE;
        w.channel = 5'($urandom_range(26));
        w.frame_control_low = 8'($urandom);
        w.frame_control_high = 8'($urandom);
        w.seq_number = 8'($urandom);
        w.dst_pan = 16'($urandom);
        w.dst_addr = {$urandom, $urandom};
        return w;
    endfunction

    // mostly legal command flow for the current state, some noise
    function automatic in_word_t gen_word();
        in_word_t w;
        int pick;
        int sel;
        w = random_word();
        pick = $urandom_range(99);
        if (pick < 10)
            w.action = 4'($urandom_range(15));
        else
            case (radio_ctx.mode)
                ST_DISABLED: w.action = ACT_ENABLE;
                ST_SLEEP: w.action = (pick < 80) ? ACT_IDLE : ACT_DISABLE;
                ST_IDLE: w.action = (pick < 50) ? ACT_RECEIVE :
                                    (pick < 88) ? ACT_TRANSMIT : ACT_SLEEP;
                ST_LISTEN: w.action = (pick < 85) ? ACT_FRAME : ACT_IDLE;
                ST_TRANSMIT: w.action = (pick < 70) ? ACT_SEND_COMPLETE :
                                        (pick < 85) ? ACT_TX_DONE_QUERY : ACT_FRAME;
                default: w.action = (pick < 75) ? ACT_FRAME : ACT_TX_DONE_QUERY;
            endcase
        if (w.action == ACT_TRANSMIT && $urandom_range(1) == 1)
            w.frame_control_low[2:0] = FTYPE_CMD;
        if (w.action == ACT_FRAME)
        begin
            if ($urandom_range(99) < 85)
                w.channel = radio_ctx.listen_channel;
            if ($urandom_range(99) < 60)
                w.frame_control_low[2:0] = FTYPE_ACK;
            if ($urandom_range(99) < 70)
                w.seq_number = radio_ctx.sent_seq;
            sel = $urandom_range(2);
            if (sel == 0)
                w.dst_pan = radio_cfg.pan_id;
            else if (sel == 1)
                w.dst_pan = BROADCAST_ID;
            sel = $urandom_range(2);
            if (w.frame_control_high[3:2] == DMODE_EXT)
            begin
                if (sel == 0)
                    w.dst_addr = radio_cfg.ext_addr;
                else if (sel == 1)
                    w.dst_addr = radio_cfg.ext_addr ^ (64'd1 << $urandom_range(63));
            end
            else if (sel == 0)
                w.dst_addr[15:0] = radio_cfg.short_addr;
            else if (sel == 1)
                w.dst_addr[15:0] = BROADCAST_ID;
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= w.action;
        channel <= w.channel;
        frame_control_low <= w.frame_control_low;
        frame_control_high <= w.frame_control_high;
        seq_number <= w.seq_number;
        dst_pan <= w.dst_pan;
        dst_addr <= w.dst_addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reply_q.push_back(radio_step(w));
        sent_count++;
    endtask

    task automatic send_op(input logic [3:0] op);
        in_word_t w;
        w = random_word();
        w.action = op;
        send_word(w);
    endtask

    task automatic send_full(input logic [3:0] op, input logic [4:0] chan,
                             input logic [7:0] fcl, input logic [7:0] fch,
                             input logic [7:0] seq, input logic [15:0] pan,
                             input logic [63:0] addr);
        in_word_t w;
        w.action = op;
        w.channel = chan;
        w.frame_control_low = fcl;
        w.frame_control_high = fch;
        w.seq_number = seq;
        w.dst_pan = pan;
        w.dst_addr = addr;
        send_word(w);
    endtask

    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PAN_ID: radio_cfg.pan_id = data[15:0];
            REG_SHORT_ADDR: radio_cfg.short_addr = data[15:0];
            REG_EXT_ADDR: radio_cfg.ext_addr = data;
            default: radio_cfg.promiscuous = data[0];
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] pan, input logic [15:0] short_id,
                                  input logic [63:0] ext, input logic prom);
        write_reg(REG_PAN_ID, CFG_DATA_W'(pan));
        write_reg(REG_SHORT_ADDR, CFG_DATA_W'(short_id));
        write_reg(REG_EXT_ADDR, ext);
        write_reg(REG_PROMISCUOUS, CFG_DATA_W'(prom));
        settings_count++;
    endtask

    task automatic test_commands();
        send_full(ACT_FRAME, 5'd0, 8'h21, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_op(ACT_SEND_COMPLETE);
        send_op(ACT_TX_DONE_QUERY);
        send_op(ACT_IDLE);
        send_op(ACT_SLEEP);
        send_op(ACT_ENABLE);
        send_op(ACT_ENABLE);
        send_op(ACT_IDLE);
        send_op(ACT_UNKNOWN_TOP);
        // ack request, mac command
        send_full(ACT_TRANSMIT, 5'd26, 8'h23, 8'hff, 8'hff, 16'hffff, '1);
        send_op(ACT_SEND_COMPLETE);
        send_full(ACT_FRAME, 5'd0, {5'd0, FTYPE_ACK}, 8'h00, 8'hfe, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd0, {5'd0, FTYPE_ACK}, 8'h00, 8'hff, 16'h0000, 64'h0);
        send_full(ACT_TRANSMIT, 5'd0, 8'h01, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_op(ACT_SEND_COMPLETE);
        send_full(ACT_TRANSMIT, 5'd0, 8'h23, 8'h00, 8'h80, 16'h0000, 64'h0);
        send_op(ACT_TX_DONE_QUERY);
        send_op(ACT_DISABLE);
    endtask

    task automatic test_rx_filter();
        // register reset values: short address zero on pan zero matches
        send_op(ACT_ENABLE);
        send_op(ACT_IDLE);
        send_full(ACT_RECEIVE, 5'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd0, 8'h21, {4'h0, DMODE_SHORT, 2'b00}, 8'h5a, 16'h0000,
                  64'hffff_ffff_ffff_0000);
        drain_replies();
        apply_settings(16'h1234, 16'hbeef, 64'h0123_4567_89ab_cdef, 1'b0);
        send_full(ACT_RECEIVE, 5'd26, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd3, 8'h21, 8'h00, 8'h11, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd26, 8'hff, {4'hf, DMODE_NONE, 2'b11}, 8'h22, 16'h0, 64'h0);
        send_full(ACT_RECEIVE, 5'd11, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd11, 8'h01, {4'h0, DMODE_SHORT, 2'b00}, 8'h33, BROADCAST_ID,
                  64'h0000_0000_0000_ffff);
        send_full(ACT_RECEIVE, 5'd11, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd11, 8'h21, {4'h0, DMODE_SHORT, 2'b00}, 8'h44, 16'h1235,
                  64'h0000_0000_0000_beef);
        send_full(ACT_RECEIVE, 5'd11, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd11, 8'h21, {4'h0, DMODE_RESERVED, 2'b00}, 8'h55, 16'h1234,
                  64'h0);
        send_full(ACT_RECEIVE, 5'd11, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd11, 8'h21, {4'h0, DMODE_EXT, 2'b00}, 8'h66, 16'h1234,
                  64'h0123_4567_89ab_cdef);
        send_full(ACT_RECEIVE, 5'd11, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd11, 8'h21, {4'h0, DMODE_EXT, 2'b00}, 8'h77, BROADCAST_ID,
                  64'h8123_4567_89ab_cdef);
        drain_replies();
        write_reg(REG_PROMISCUOUS, CFG_DATA_W'(1));
        send_full(ACT_RECEIVE, 5'd5, 8'h00, 8'h00, 8'h00, 16'h0000, 64'h0);
        send_full(ACT_FRAME, 5'd5, 8'h21, {4'h0, DMODE_RESERVED, 2'b00}, 8'h88, 16'h0, 64'h0);
    endtask

    task automatic test_backpressure();
        drain_replies();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_request = 64;
        repeat (24) send_word(gen_word());
        drain_replies();
    endtask

    task automatic test_random();
        int ph;
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_replies();
            case (ph)
                0: apply_settings(16'h0000, 16'h0000, 64'h0, 1'b0);
                1: apply_settings(16'hffff, 16'hffff, '1, 1'b0);
                2: apply_settings(16'($urandom), 16'($urandom), {$urandom, $urandom}, 1'b1);
                default: apply_settings(16'($urandom), 16'($urandom), {$urandom, $urandom},
                                        $urandom_range(3) == 0);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 67; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 67; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat (WORDS_PER_PHASE) send_word(gen_word());
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // result word checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected, expected none, actual %0h",
                             $time, {status, event_kind, radio_state});
            end
            else
            begin
                want_reply = reply_q.pop_front();
                check_field("status", 8'(want_reply.status), 8'(status));
                check_field("event_kind", 8'(want_reply.event_kind), 8'(event_kind));
                check_field("data_pending", 8'(want_reply.data_pending), 8'(data_pending));
                check_field("send_ack", 8'(want_reply.send_ack), 8'(send_ack));
                check_field("ack_seq", want_reply.ack_seq, ack_seq);
                check_field("ack_channel", 8'(want_reply.ack_channel), 8'(ack_channel));
                check_field("radio_state", 8'(want_reply.radio_state), 8'(radio_state));
                checked_count++;
            end
        end
    end

    // receiver with random stalls and an on-request long hold
    always @(negedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_commands();
        test_rx_filter();
        test_backpressure();
        test_random();
        drain_replies();
        repeat (4) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d register settings",
                 sent_count, checked_count, settings_count);
        $display("covered commands, transmit and ack wait, rx filtering, stalls and back-pressure");
        if (fail_count == 0 && reply_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
